// ----- hw/rtl/kmc_pkg.sv -----
// ----------------------------------------------------------------------------
// kmc_pkg
// shared types and constants of the k-means clustering engine
// ----------------------------------------------------------------------------
package kmc_pkg;

   localparam int FEAT_W = 16;
   localparam int CSR_DATA_W = 11;

   // command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   typedef enum logic [1:0] {
      CSR_NUM_POINTS,
      CSR_NUM_DIMS,
      CSR_NUM_CLUSTERS,
      CSR_MAX_ITERATIONS
   } csr_idx_type;

   localparam logic [10:0] RST_NUM_POINTS     = 11'd1;
   localparam logic [8:0]  RST_NUM_DIMS       = 9'd1;
   localparam logic [4:0]  RST_NUM_CLUSTERS   = 5'd2;
   localparam logic [9:0]  RST_MAX_ITERATIONS = 10'd100;

   typedef struct packed {
      logic [1:0]        command;
      logic [9:0]        point_index;
      logic [7:0]        dim_index;
      logic [FEAT_W-1:0] feature_value;
   } req_type;

   typedef struct packed {
      logic [10:0] iterations_run;
      logic        converged;
      logic [10:0] final_changes;
      logic [3:0]  cluster_id;
      logic [10:0] cluster_size;
   } rsp_type;

endpackage

// ----- hw/rtl/kmc_ram.sv -----
// ----------------------------------------------------------------------------
// kmc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/kmc_div.sv -----
// ----------------------------------------------------------------------------
// kmc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kmc_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W:0]    trial;
   logic              ge;
   logic [DEN_W:0]    diff;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge    = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            num_ff  <= num_ff << 1;
            rem_ff  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff  <= {quo_ff[NUM_W-2:0], ge};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- hw/rtl/kmeans_clustering_engine.sv -----
// ----------------------------------------------------------------------------
// kmeans_clustering_engine
// lloyd k-means over points held in on-chip ram
// ----------------------------------------------------------------------------
// A load transaction writes one feature of one point in the cycle that it is
// accepted. A read transaction reads the point's cluster and that cluster's
// size into a pending result and returns it once the output slot is free. A
// run transaction assigns points round-robin and then repeats lloyd
// iterations, each one a clear sweep, a sum pass, a centroid pass through one
// shared bit-serial divider, and a reassignment pass through one shared
// squarer and accumulator; the result comes out when an iteration changes
// nothing or the limit is hit. The block takes one transaction at a time and
// holds req_stall high while it works. After reset the assignment ram is
// swept to zero, entry by entry, before the first transaction is taken.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = 1024,
   parameter int MAX_DIMS     = 256,
   parameter int MAX_CLUSTERS = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KW     = $clog2(MAX_CLUSTERS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = FEAT_W + PW;
   localparam int CEN_W  = FEAT_W + FRAC_BITS;
   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int SQ_W   = 2 * CEN_W;
   localparam int DIST_W = 64;
   localparam int FE_DEPTH = MAX_POINTS * (1 << DW);
   localparam int CL_DEPTH = MAX_CLUSTERS * (1 << DW);

   typedef enum logic [4:0] {
      S_WIPE, S_IDLE, S_RD_WAIT, S_INIT, S_CHECK, S_CLR,
      S_ACC_A, S_ACC_AW, S_ACC_RD, S_ACC_WR,
      S_DIV_RD, S_DIV_GO, S_DIV_WAIT,
      S_RE_START, S_RE_OLD, S_RE_RD, S_RE_DIFF, S_RE_MUL, S_RE_ACC,
      S_RE_PICK, S_RE_PUT, S_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [10:0] num_points_ff;
   logic [8:0]  num_dims_ff;
   logic [4:0]  num_clusters_ff;
   logic [9:0]  max_iter_ff;

   // loop control
   logic [PW-1:0]     i_ff;
   logic [DW-1:0]     j_ff;
   logic [KW-1:0]     c_ff;
   logic [KW-1:0]     r_ff;
   logic [KW-1:0]     a_ff;
   logic [KW-1:0]     old_ff;
   logic [KW-1:0]     best_ff;
   logic [PW-1:0]     n_m1_ff;
   logic [DW-1:0]     d_m1_ff;
   logic [KW-1:0]     k_m1_ff;
   logic [9:0]        iters_ff;
   logic [CNT_W-1:0]  changes_ff;
   logic              rd_ok_ff;

   // distance datapath
   logic [CEN_W-1:0]  diff_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] best_d_ff;

   logic [CNT_W-1:0]  cnt_ff [MAX_CLUSTERS];

   rsp_type pend_ff;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;

   // clamped register values, minus one
   logic [PW-1:0] n_m1;
   logic [DW-1:0] d_m1;
   logic [KW-1:0] k_m1;

   logic req_acc;
   logic pt_ok;
   logic dm_ok;
   logic out_free;
   logic i_last;
   logic j_last;
   logic c_last;
   logic r_last;

   // ram ports
   logic                  fe_we;
   logic [PW+DW-1:0]      fe_waddr;
   logic [PW+DW-1:0]      fe_raddr;
   logic [FEAT_W-1:0]     fe_rd;
   logic                  sm_we;
   logic [KW+DW-1:0]      sm_waddr;
   logic [SUM_W-1:0]      sm_wdata;
   logic [KW+DW-1:0]      sm_raddr;
   logic [SUM_W-1:0]      sm_rd;
   logic                  cn_we;
   logic [CEN_W-1:0]      cn_wdata;
   logic [KW+DW-1:0]      cn_addr;
   logic [CEN_W-1:0]      cn_rd;
   logic                  as_we;
   logic [PW-1:0]         as_waddr;
   logic [KW-1:0]         as_wdata;
   logic [PW-1:0]         as_raddr;
   logic [KW-1:0]         as_rd;

   logic [KW-1:0]         cnt_sel;
   logic [CNT_W-1:0]      cnt_rd;

   logic                  div_start;
   logic                  div_done;
   logic [NUM_W-1:0]      div_quo;

   logic [CEN_W-1:0]      p_val;
   logic [DIST_W:0]       dist_sum;
   logic [DIST_W-1:0]     dist_sat;

   kmc_ram #(.WIDTH(FEAT_W), .DEPTH(FE_DEPTH)) u_feat (
      .clock(clock), .wr_en(fe_we), .wr_addr(fe_waddr), .wr_data(req_data.feature_value),
      .rd_addr(fe_raddr), .rd_data(fe_rd)
   );

   kmc_ram #(.WIDTH(SUM_W), .DEPTH(CL_DEPTH)) u_sums (
      .clock(clock), .wr_en(sm_we), .wr_addr(sm_waddr), .wr_data(sm_wdata),
      .rd_addr(sm_raddr), .rd_data(sm_rd)
   );

   kmc_ram #(.WIDTH(CEN_W), .DEPTH(CL_DEPTH)) u_cent (
      .clock(clock), .wr_en(cn_we), .wr_addr(cn_addr), .wr_data(cn_wdata),
      .rd_addr(cn_addr), .rd_data(cn_rd)
   );

   kmc_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_asg (
      .clock(clock), .wr_en(as_we), .wr_addr(as_waddr), .wr_data(as_wdata),
      .rd_addr(as_raddr), .rd_data(as_rd)
   );

   // centroid = floor((sum << FRAC_BITS) / count)
   kmc_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(NUM_W'(sm_rd) << FRAC_BITS), .den(cnt_rd),
      .done(div_done), .quo(div_quo)
   );

   // out-of-range register values clamp into range
   always_comb begin
      if (num_points_ff == '0) begin
         n_m1 = '0;
      end else if (int'(num_points_ff) > MAX_POINTS) begin
         n_m1 = PW'(MAX_POINTS - 1);
      end else begin
         n_m1 = PW'(num_points_ff - 11'd1);
      end
      if (num_dims_ff == '0) begin
         d_m1 = '0;
      end else if (int'(num_dims_ff) > MAX_DIMS) begin
         d_m1 = DW'(MAX_DIMS - 1);
      end else begin
         d_m1 = DW'(num_dims_ff - 9'd1);
      end
      if (num_clusters_ff == '0) begin
         k_m1 = '0;
      end else if (int'(num_clusters_ff) > MAX_CLUSTERS) begin
         k_m1 = KW'(MAX_CLUSTERS - 1);
      end else begin
         k_m1 = KW'(num_clusters_ff - 5'd1);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign pt_ok     = (int'(req_data.point_index) < MAX_POINTS);
   assign dm_ok     = (int'(req_data.dim_index) < MAX_DIMS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign i_last    = (i_ff == n_m1_ff);
   assign j_last    = (j_ff == d_m1_ff);
   assign c_last    = (c_ff == k_m1_ff);
   assign r_last    = (r_ff == k_m1_ff);

   // single read port on the member counts
   always_comb begin
      case (state_ff)
         S_RD_WAIT: cnt_sel = as_rd;
         S_INIT:    cnt_sel = r_ff;
         S_RE_PUT:  cnt_sel = best_ff;
         default:   cnt_sel = c_ff;
      endcase
      cnt_rd = (int'(cnt_sel) < MAX_CLUSTERS) ? cnt_ff[cnt_sel] : '0;
   end

   // squared distance step: diff, square, saturating sum
   always_comb begin
      p_val    = CEN_W'(fe_rd) << FRAC_BITS;
      dist_sum = {1'b0, dist_ff} + (DIST_W + 1)'(sq_ff);
      dist_sat = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
   end

   // ram control
   always_comb begin
      fe_we     = (state_ff == S_IDLE) && req_acc && (req_data.command == CMD_LOAD)
                  && pt_ok && dm_ok;
      fe_waddr  = {PW'(req_data.point_index), DW'(req_data.dim_index)};
      fe_raddr  = {i_ff, j_ff};
      sm_we     = 1'b0;
      sm_waddr  = {a_ff, j_ff};
      sm_wdata  = sm_rd + SUM_W'(fe_rd);
      sm_raddr  = (state_ff == S_DIV_RD) ? {c_ff, j_ff} : {a_ff, j_ff};
      cn_we     = 1'b0;
      cn_wdata  = div_quo[CEN_W-1:0];
      cn_addr   = {c_ff, j_ff};
      as_we     = 1'b0;
      as_waddr  = i_ff;
      as_wdata  = best_ff;
      as_raddr  = (state_ff == S_IDLE) ? PW'(req_data.point_index) : i_ff;
      div_start = 1'b0;
      case (state_ff)
         S_WIPE: begin
            as_we    = 1'b1;
            as_wdata = '0;
         end
         S_INIT: begin
            as_we    = 1'b1;
            as_wdata = r_ff;
         end
         S_CLR: begin
            sm_we    = 1'b1;
            sm_waddr = {c_ff, j_ff};
            sm_wdata = '0;
         end
         S_ACC_WR: begin
            sm_we = 1'b1;
         end
         S_DIV_GO: begin
            if (cnt_rd == '0) begin
               cn_we    = 1'b1;
               cn_wdata = '0;
            end else begin
               div_start = 1'b1;
            end
         end
         S_DIV_WAIT: begin
            cn_we = div_done;
         end
         S_RE_PUT: begin
            as_we = (old_ff != best_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_WIPE;
         i_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
         num_points_ff   <= RST_NUM_POINTS;
         num_dims_ff     <= RST_NUM_DIMS;
         num_clusters_ff <= RST_NUM_CLUSTERS;
         max_iter_ff     <= RST_MAX_ITERATIONS;
         for (int q = 0; q < MAX_CLUSTERS; q++) begin
            cnt_ff[q] <= '0;
         end
      end else begin
         // configuration writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_NUM_POINTS:     num_points_ff   <= csr_data;
               CSR_NUM_DIMS:       num_dims_ff     <= csr_data[8:0];
               CSR_NUM_CLUSTERS:   num_clusters_ff <= csr_data[4:0];
               CSR_MAX_ITERATIONS: max_iter_ff     <= csr_data[9:0];
            endcase
         end

         // output slot: loaded from the pending result, freed when taken
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_WIPE: begin
               i_ff <= i_ff + 1'b1;
               if (i_ff == PW'(MAX_POINTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  case (req_data.command)
                     CMD_RUN: begin
                        n_m1_ff    <= n_m1;
                        d_m1_ff    <= d_m1;
                        k_m1_ff    <= k_m1;
                        iters_ff   <= '0;
                        changes_ff <= CNT_W'(n_m1) + 1'b1;
                        i_ff       <= '0;
                        r_ff       <= '0;
                        for (int q = 0; q < MAX_CLUSTERS; q++) begin
                           cnt_ff[q] <= '0;
                        end
                        state_ff   <= S_INIT;
                     end
                     CMD_READ: begin
                        rd_ok_ff <= pt_ok;
                        state_ff <= S_RD_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RD_WAIT: begin
               pend_ff.iterations_run <= '0;
               pend_ff.converged      <= 1'b0;
               pend_ff.final_changes  <= '0;
               pend_ff.cluster_id     <= rd_ok_ff ? 4'(as_rd) : '0;
               pend_ff.cluster_size   <= rd_ok_ff ? 11'(cnt_rd) : '0;
               state_ff               <= S_EMIT;
            end
            // round-robin start, counts built one member at a time
            S_INIT: begin
               cnt_ff[cnt_sel] <= cnt_rd + 1'b1;
               r_ff <= r_last ? '0 : r_ff + 1'b1;
               i_ff <= i_ff + 1'b1;
               if (i_last) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (changes_ff == '0 || iters_ff >= max_iter_ff) begin
                  pend_ff.iterations_run <= 11'(iters_ff);
                  pend_ff.converged      <= (changes_ff == '0);
                  pend_ff.final_changes  <= 11'(changes_ff);
                  pend_ff.cluster_id     <= '0;
                  pend_ff.cluster_size   <= '0;
                  state_ff               <= S_EMIT;
               end else begin
                  c_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= S_CLR;
               end
            end
            S_CLR: begin
               j_ff <= j_last ? '0 : j_ff + 1'b1;
               if (j_last) begin
                  c_ff <= c_ff + 1'b1;
                  if (c_last) begin
                     i_ff     <= '0;
                     state_ff <= S_ACC_A;
                  end
               end
            end
            S_ACC_A: begin
               state_ff <= S_ACC_AW;
            end
            S_ACC_AW: begin
               // stale cluster index from a larger k folds into cluster zero
               a_ff     <= (as_rd > k_m1_ff) ? '0 : as_rd;
               j_ff     <= '0;
               state_ff <= S_ACC_RD;
            end
            S_ACC_RD: begin
               state_ff <= S_ACC_WR;
            end
            S_ACC_WR: begin
               if (j_last) begin
                  j_ff <= '0;
                  if (i_last) begin
                     c_ff     <= '0;
                     state_ff <= S_DIV_RD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_ACC_A;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_ACC_RD;
               end
            end
            S_DIV_RD: begin
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO, S_DIV_WAIT: begin
               if ((state_ff == S_DIV_GO && cnt_rd == '0)
                   || (state_ff == S_DIV_WAIT && div_done)) begin
                  j_ff <= j_last ? '0 : j_ff + 1'b1;
                  if (j_last) begin
                     c_ff <= c_ff + 1'b1;
                  end
                  if (j_last && c_last) begin
                     for (int q = 0; q < MAX_CLUSTERS; q++) begin
                        cnt_ff[q] <= '0;
                     end
                     i_ff       <= '0;
                     changes_ff <= '0;
                     state_ff   <= S_RE_START;
                  end else begin
                     state_ff <= S_DIV_RD;
                  end
               end else if (state_ff == S_DIV_GO) begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_RE_START: begin
               c_ff     <= '0;
               j_ff     <= '0;
               dist_ff  <= '0;
               state_ff <= S_RE_OLD;
            end
            S_RE_OLD: begin
               old_ff   <= as_rd;
               state_ff <= S_RE_RD;
            end
            S_RE_RD: begin
               state_ff <= S_RE_DIFF;
            end
            S_RE_DIFF: begin
               diff_ff  <= (p_val > cn_rd) ? p_val - cn_rd : cn_rd - p_val;
               state_ff <= S_RE_MUL;
            end
            S_RE_MUL: begin
               sq_ff    <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
               state_ff <= S_RE_ACC;
            end
            S_RE_ACC: begin
               dist_ff <= dist_sat;
               if (j_last) begin
                  state_ff <= S_RE_PICK;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_RE_RD;
               end
            end
            // strict less-than keeps ties on the lowest cluster
            S_RE_PICK: begin
               if (c_ff == '0 || dist_ff < best_d_ff) begin
                  best_ff   <= c_ff;
                  best_d_ff <= dist_ff;
               end
               if (c_last) begin
                  state_ff <= S_RE_PUT;
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  j_ff     <= '0;
                  dist_ff  <= '0;
                  state_ff <= S_RE_RD;
               end
            end
            S_RE_PUT: begin
               cnt_ff[cnt_sel] <= cnt_rd + 1'b1;
               if (old_ff != best_ff) begin
                  changes_ff <= changes_ff + 1'b1;
               end
               if (i_last) begin
                  iters_ff <= iters_ff + 1'b1;
                  state_ff <= S_CHECK;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_RE_START;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sums are only ever addressed inside the active cluster range
   a_acc_cluster: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC_RD) |-> (a_ff <= k_m1_ff))
      else $error("sum pass addressing a cluster beyond k");

   // divider completes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider done outside the centroid wait");

   // a pending result moves to the output once the slot is free
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("pending result not delivered");

   // iteration count never passes the limit
   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (iters_ff <= max_iter_ff))
      else $error("iteration count beyond limit");

endmodule

// ----- tb/tb_kmeans_clustering_engine.sv -----
// ----------------------------------------------------------------------------
// tb_kmeans_clustering_engine
// self-checking bench for the lloyd k-means engine
// ----------------------------------------------------------------------------
// A bit-exact clustering predictor shadows the feature store, assignments and
// cluster counts. Directed tests cover reset values, register extremes and
// clamping, ties, empty clusters and the unknown command. A pressure test and
// many random clustering phases follow. Every run and read transaction is
// scored against the predicted response.
// ----------------------------------------------------------------------------
module tb_kmeans_clustering_engine
   import kmc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_MAX       = 1024;
   localparam int D_MAX       = 256;
   localparam int K_MAX       = 16;
   localparam int FRAC        = 8;
   localparam int ITEM_TARGET = 1450;
   localparam int IDLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES = 300;
   // command code the block must ignore
   localparam logic [1:0] CMD_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   csr_idx_type csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   kmeans_clustering_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow state of the engine
   bit [15:0]       feat_mem [N_MAX*D_MAX];
   bit [63:0]       centroid_mem [K_MAX][D_MAX];
   int unsigned     member_of [N_MAX];
   int unsigned     member_count [K_MAX];
   int unsigned     reg_points, reg_dims, reg_clusters, reg_iter_limit;

   rsp_type         pending_rsps [$];
   int              items_sent;
   int              mismatches;
   int              idle_cycles;
   bit              no_gaps;
   bit              hold_request;
   int              hold_left;
   int              rsp_gap_left;

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // one lloyd iteration; returns the number of reassigned points
   function automatic int unsigned lloyd_pass(int unsigned n, int unsigned d,
                                              int unsigned k);
      longint unsigned sums [K_MAX][D_MAX];
      longint unsigned dsum, best_dist, p, q, diff, sq;
      int unsigned     a, best, changes;
      changes = 0;
      for (int c = 0; c < K_MAX; c++)
         for (int j = 0; j < D_MAX; j++) sums[c][j] = 0;
      for (int i = 0; i < n; i++) begin
         a = member_of[i];
         if (a >= k) a = 0;
         for (int j = 0; j < d; j++) sums[a][j] += feat_mem[i*D_MAX + j];
      end
      for (int c = 0; c < k; c++)
         for (int j = 0; j < d; j++)
            centroid_mem[c][j] = (member_count[c] > 0) ?
               (sums[c][j] << FRAC) / member_count[c] : 64'd0;
      for (int c = 0; c < K_MAX; c++) member_count[c] = 0;
      for (int i = 0; i < n; i++) begin
         best = 0;
         best_dist = 0;
         for (int c = 0; c < k; c++) begin
            dsum = 0;
            for (int j = 0; j < d; j++) begin
               p = longint'(feat_mem[i*D_MAX + j]) << FRAC;
               q = centroid_mem[c][j];
               diff = (p > q) ? p - q : q - p;
               sq = diff * diff;
               // saturating distance sum
               if (dsum > ~64'd0 - sq) dsum = ~64'd0;
               else dsum += sq;
            end
            // strict less keeps ties on the lowest cluster
            if (c == 0 || dsum < best_dist) begin
               best = c;
               best_dist = dsum;
            end
         end
         member_count[best]++;
         if (member_of[i] != best) begin
            changes++;
            member_of[i] = best;
         end
      end
      return changes;
   endfunction

   // full run: round-robin start, then iterate to convergence or the limit
   function automatic rsp_type predict_run();
      rsp_type     r;
      int unsigned n, d, k, iters, changes;
      n = clamp_to(reg_points, N_MAX);
      d = clamp_to(reg_dims, D_MAX);
      k = clamp_to(reg_clusters, K_MAX);
      for (int i = 0; i < n; i++) member_of[i] = i % k;
      for (int c = 0; c < K_MAX; c++)
         member_count[c] = (c < k) ? n / k + ((c < n % k) ? 1 : 0) : 0;
      iters = 0;
      changes = n;
      while (changes > 0 && iters < reg_iter_limit) begin
         changes = lloyd_pass(n, d, k);
         iters++;
      end
      r = '0;
      r.iterations_run = iters[10:0];
      r.converged      = (changes == 0);
      r.final_changes  = changes[10:0];
      return r;
   endfunction

   function automatic rsp_type predict_read(int unsigned pt);
      rsp_type     r;
      int unsigned a;
      r = '0;
      a = member_of[pt];
      r.cluster_id   = a[3:0];
      r.cluster_size = (a < K_MAX) ? member_count[a][10:0] : 11'd0;
      return r;
   endfunction

   // shadow update for one accepted transaction
   task automatic apply_cmd(req_type r);
      case (r.command)
         CMD_LOAD: feat_mem[r.point_index*D_MAX + r.dim_index] = r.feature_value;
         CMD_RUN:  pending_rsps.push_back(predict_run());
         CMD_READ: pending_rsps.push_back(predict_read(r.point_index));
         default: ;
      endcase
   endtask

   // offer one transaction; valid stays up if the next one follows directly
   task automatic send_cmd(req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      apply_cmd(r);
      items_sent++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic load_feature(int pt, int dm, int unsigned val);
      req_type r;
      r = '0;
      r.command = CMD_LOAD;
      r.point_index = pt[9:0];
      r.dim_index = dm[7:0];
      r.feature_value = val[15:0];
      send_cmd(r);
   endtask

   task automatic issue(logic [1:0] cmd, int pt);
      req_type r;
      r = '0;
      r.command = cmd;
      r.point_index = pt[9:0];
      r.dim_index = $urandom_range(0, 255);
      r.feature_value = $urandom_range(0, 65535);
      send_cmd(r);
   endtask

   // quiet point: all responses in and any load fully retired
   task automatic wait_idle();
      end_burst();
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int unsigned val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_POINTS:     reg_points     = val & 11'h7FF;
         CSR_NUM_DIMS:       reg_dims       = val & 9'h1FF;
         CSR_NUM_CLUSTERS:   reg_clusters   = val & 5'h1F;
         CSR_MAX_ITERATIONS: reg_iter_limit = val & 10'h3FF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(int unsigned n, int unsigned d, int unsigned k,
                             int unsigned iters);
      write_csr(CSR_NUM_POINTS, n);
      write_csr(CSR_NUM_DIMS, d);
      write_csr(CSR_NUM_CLUSTERS, k);
      write_csr(CSR_MAX_ITERATIONS, iters);
   endtask

   // ---------------------------------------------------------------- tests

   // reset configuration: one point, one dim, two clusters
   task automatic test_reset_config();
      load_feature(0, 0, 16'hFFFF);
      issue(CMD_RUN, 0);
      issue(CMD_READ, 0);
      issue(CMD_READ, 1023);
      wait_idle();
   endtask

   // largest legal sizes with no iterations, then clamped register values
   task automatic test_register_extremes();
      set_config(N_MAX, D_MAX, K_MAX, 0);
      issue(CMD_RUN, 0);
      issue(CMD_READ, 1023);
      wait_idle();
      // zeros count as one; long iteration limit on a single point
      set_config(0, 0, 0, 1023);
      load_feature(0, 255, 0);
      issue(CMD_RUN, 0);
      issue(CMD_READ, 512);
      wait_idle();
      // all-ones registers clamp to the maximum
      set_config(11'h7FF, 9'h1FF, 5'h1F, 0);
      issue(CMD_RUN, 0);
      issue(CMD_READ, 1022);
      wait_idle();
   endtask

   // identical points tie onto cluster 0, the rest go empty
   task automatic test_ties_and_empty();
      set_config(4, 1, 3, 10);
      for (int i = 0; i < 4; i++) load_feature(i, 0, 500);
      issue(CMD_RUN, 0);
      issue(CMD_READ, 3);
      issue(CMD_READ, 0);
      wait_idle();
   endtask

   // unused command code must be swallowed without a response
   task automatic test_unknown_command();
      issue(CMD_NONE, 5);
      issue(CMD_READ, 2);
      wait_idle();
   endtask

   // receiver holds off while reads keep coming, so the engine backs up
   task automatic test_backpressure();
      no_gaps = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) issue(CMD_READ, i % 4);
      no_gaps = 1'b0;
      wait_idle();
   endtask

   // random clustering phases with well-formed data sets
   task automatic test_random_clustering();
      int unsigned n, d, k, iters, kc, spread;
      int unsigned centers [8][4];
      while (items_sent < ITEM_TARGET) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         d = $urandom_range(1, 3);
         k = (n > 12) ? $urandom_range(1, 3) : $urandom_range(1, 5);
         if ($urandom_range(0, 19) == 0) k = $urandom_range(6, 16);
         iters = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
         no_gaps = ($urandom_range(0, 3) == 0);
         set_config(n, d, k, iters);
         kc = $urandom_range(1, 4);
         spread = 1 << $urandom_range(0, 12);
         for (int c = 0; c < 8; c++)
            for (int j = 0; j < 4; j++) centers[c][j] = $urandom_range(0, 65535);
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < d; j++)
               load_feature(i, j, centers[$urandom_range(0, kc - 1)][j] +
                            $urandom_range(0, spread));
            // noise: ignored command or a load well outside the data set
            if ($urandom_range(0, 9) == 0) issue(CMD_NONE, $urandom_range(0, 1023));
            if ($urandom_range(0, 9) == 0)
               load_feature($urandom_range(512, 1023), $urandom_range(0, 255),
                            $urandom_range(0, 65535));
         end
         repeat ($urandom_range(1, 2)) issue(CMD_RUN, $urandom_range(0, 1023));
         repeat ($urandom_range(3, 8))
            issue(CMD_READ, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, n - 1));
         wait_idle();
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------ response side

   // receiver stall pattern, with the long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall = 1'b1;
      end else if (rsp_gap_left > 0) begin
         rsp_stall = 1'b1;
         rsp_gap_left--;
      end else begin
         rsp_stall = 1'b0;
         rsp_gap_left = pick_gap();
      end
   end

   // scoreboard: each response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transaction: %p", rsp_data);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.iterations_run !== want.iterations_run ||
                rsp_data.converged      !== want.converged ||
                rsp_data.final_changes  !== want.final_changes ||
                rsp_data.cluster_id     !== want.cluster_id ||
                rsp_data.cluster_size   !== want.cluster_size) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("[kmeans_clustering_engine] ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NUM_POINTS;
      csr_data = '0;
      rsp_stall = 1'b0;
      items_sent = 0;
      mismatches = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      rsp_gap_left = 0;
      reg_points = RST_NUM_POINTS;
      reg_dims = RST_NUM_DIMS;
      reg_clusters = RST_NUM_CLUSTERS;
      reg_iter_limit = RST_MAX_ITERATIONS;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_reset_config();
      test_register_extremes();
      test_ties_and_empty();
      test_unknown_command();
      test_backpressure();
      test_random_clustering();

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("[kmeans_clustering_engine] OK");
      end else begin
         $display("[kmeans_clustering_engine] ERROR");
      end
      $finish;
   end

endmodule
